// ===== hw/rtl/cpd_pkg.sv =====
`timescale 1ns / 1ps

package cpd_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int GUARD_SHIFT   = 8;
  localparam int ANGLE_WIDTH   = 16;

  // CORDIC x/y: coordinate, guard bits, CORDIC gain and sign.
  localparam int CW_WIDTH   = COORD_WIDTH + GUARD_SHIFT + 3;
  // Angle accumulator in degrees * 2^16, including the half-turn offset.
  localparam int Z_WIDTH     = 26;
  localparam int ROUND_SHIFT = 9;
  localparam int ANG_WIDTH   = Z_WIDTH - ROUND_SHIFT;
  localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
  localparam int SQRT_STEPS  = COORD_WIDTH;
  localparam int CORE_DEPTH  = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

  localparam logic signed [Z_WIDTH-1:0]   DEG180_Z   = Z_WIDTH'(11796480);
  localparam logic signed [Z_WIDTH-1:0]   ROUND_BIAS = Z_WIDTH'(256);
  localparam logic signed [ANG_WIDTH-1:0] DEG90_Q7   = ANG_WIDTH'(11520);
  localparam logic signed [ANG_WIDTH-1:0] DEG180_Q7  = ANG_WIDTH'(23040);

  typedef enum logic [3:0] {
    LOC_ORIGIN = 4'd0,
    LOC_QUAD1  = 4'd1,
    LOC_QUAD2  = 4'd2,
    LOC_QUAD3  = 4'd3,
    LOC_QUAD4  = 4'd4,
    LOC_POS_Y  = 4'd5,
    LOC_NEG_Y  = 4'd6,
    LOC_POS_X  = 4'd7,
    LOC_NEG_X  = 4'd8
  } loc_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
  } coord_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0]        radius;
    logic signed [ANGLE_WIDTH-1:0] angle_deg;
    loc_t                          location;
    logic                          polar_valid;
  } polar_t;

  // One word in flight through the CORDIC / square-root core.
  typedef struct packed {
    logic signed [CW_WIDTH-1:0] cx;
    logic signed [CW_WIDTH-1:0] cy;
    logic signed [Z_WIDTH-1:0]  z;
    logic [SQ_WIDTH-1:0]        rem;
    logic [SQ_WIDTH-1:0]        root;
    loc_t                       location;
    logic                       flip;
    logic                       y_pos;
  } core_t;

  // atan(2^-i) in degrees * 2^16, rounded to nearest.
  function automatic int atan_deg_q16(input int idx);
    int val;
    case (idx)
      0:  val = 2949120;
      1:  val = 1740967;
      2:  val = 919879;
      3:  val = 466945;
      4:  val = 234379;
      5:  val = 117304;
      6:  val = 58666;
      7:  val = 29335;
      8:  val = 14668;
      9:  val = 7334;
      10: val = 3667;
      11: val = 1833;
      12: val = 917;
      13: val = 458;
      14: val = 229;
      15: val = 115;
      16: val = 57;
      17: val = 29;
      18: val = 14;
      19: val = 7;
      20: val = 4;
      21: val = 2;
      22: val = 1;
      default: val = 0;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/cartesian_to_polar_degrees.sv =====
`timescale 1ns / 1ps

// Cartesian to polar converter. Each word on the coord channel is one signed
// Q8.8 point (x_coord, y_coord); each word on the result channel gives the
// truncated magnitude radius (unsigned Q8.8), the four-quadrant angle
// angle_deg in degrees (signed Q9.7, -180 to +180), a location class
// (origin, quadrant I..IV, or one of the four half-axes) and polar_valid,
// which is set only for points strictly inside a quadrant. Axis points
// still get their exact radius and angle. A new point is accepted every
// clock while coord_stall is low; the pipeline is two front stages, then
// the core, in which each stage performs one CORDIC micro-rotation and
// resolves one bit of the square root, and then two back stages. Every
// stage holds its own valid bit, so stall on the result side fills empty
// stages first and only then reaches coord_stall.

module cartesian_to_polar_degrees
  import cpd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   coord_valid,
  output logic   coord_stall,
  input  coord_t coord,
  output logic   result_valid,
  input  logic   result_stall,
  output polar_t result
);

  typedef struct packed {
    logic signed [CW_WIDTH-1:0] cx;
    logic signed [CW_WIDTH-1:0] cy;
    logic [SQ_WIDTH-1:0]        sq_x;
    logic [SQ_WIDTH-1:0]        sq_y;
    loc_t                       location;
    logic                       flip;
    logic                       y_pos;
  } front_t;

  typedef struct packed {
    logic signed [ANG_WIDTH-1:0] ang;
    logic [COORD_WIDTH-1:0]      radius;
    loc_t                        location;
  } round_t;

  // Stage registers and their valid bits.
  front_t front;
  logic   front_vld;
  core_t  seed;
  logic   seed_vld;
  round_t rounded;
  logic   rounded_vld;

  // Per-stage load enables.
  logic load_front;
  logic load_seed;
  logic load_round;
  logic load_result;

  logic  core_stall;
  logic  core_valid;
  core_t core_word;

  assign load_result = !result_valid || !result_stall;
  assign load_round  = !rounded_vld || load_result;
  assign load_seed   = !seed_vld || !core_stall;
  assign load_front  = !front_vld || load_seed;
  assign coord_stall = !load_front;

  // ---------------------------------------------------------------------
  // Front stage: classify the point, fold the left half-plane onto the
  // right one, and square both magnitudes.
  // ---------------------------------------------------------------------
  logic                          x_neg;
  logic                          y_neg;
  logic                          x_zero;
  logic                          y_zero;
  logic signed [COORD_WIDTH:0]   x_ext;
  logic signed [COORD_WIDTH:0]   y_ext;
  logic signed [COORD_WIDTH:0]   x_fold;
  logic signed [COORD_WIDTH:0]   y_fold;
  logic [COORD_WIDTH-1:0]        x_mag;
  logic [COORD_WIDTH-1:0]        y_mag;
  front_t                        front_next;

  always_comb begin
    x_neg  = coord.x_coord[COORD_WIDTH-1];
    y_neg  = coord.y_coord[COORD_WIDTH-1];
    x_zero = (coord.x_coord == '0);
    y_zero = (coord.y_coord == '0);
    x_ext  = {coord.x_coord[COORD_WIDTH-1], coord.x_coord};
    y_ext  = {coord.y_coord[COORD_WIDTH-1], coord.y_coord};
    // Negate both coordinates when x < 0; the half-turn is added back later.
    x_fold = x_neg ? -x_ext : x_ext;
    y_fold = x_neg ? -y_ext : y_ext;
    x_mag  = x_neg ? COORD_WIDTH'(-x_ext) : COORD_WIDTH'(x_ext);
    y_mag  = y_neg ? COORD_WIDTH'(-y_ext) : COORD_WIDTH'(y_ext);

    front_next.cx    = CW_WIDTH'(x_fold) <<< GUARD_SHIFT;
    front_next.cy    = CW_WIDTH'(y_fold) <<< GUARD_SHIFT;
    front_next.sq_x  = SQ_WIDTH'(x_mag) * SQ_WIDTH'(x_mag);
    front_next.sq_y  = SQ_WIDTH'(y_mag) * SQ_WIDTH'(y_mag);
    front_next.flip  = x_neg;
    front_next.y_pos = !y_neg && !y_zero;

    if (x_zero && y_zero) begin
      front_next.location = LOC_ORIGIN;
    end else if (x_zero) begin
      front_next.location = y_neg ? LOC_NEG_Y : LOC_POS_Y;
    end else if (y_zero) begin
      front_next.location = x_neg ? LOC_NEG_X : LOC_POS_X;
    end else if (!x_neg && !y_neg) begin
      front_next.location = LOC_QUAD1;
    end else if (x_neg && !y_neg) begin
      front_next.location = LOC_QUAD2;
    end else if (x_neg) begin
      front_next.location = LOC_QUAD3;
    end else begin
      front_next.location = LOC_QUAD4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_vld <= 1'b0;
    end else if (load_front) begin
      front_vld <= coord_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_front) begin
      front <= front_next;
    end
  end

  // ---------------------------------------------------------------------
  // Seed stage: sum of squares becomes the square-root remainder; the
  // angle accumulator starts at zero.
  // ---------------------------------------------------------------------
  core_t seed_next;

  always_comb begin
    seed_next.cx       = front.cx;
    seed_next.cy       = front.cy;
    seed_next.z        = '0;
    seed_next.rem      = front.sq_x + front.sq_y;
    seed_next.root     = '0;
    seed_next.location = front.location;
    seed_next.flip     = front.flip;
    seed_next.y_pos    = front.y_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_vld <= 1'b0;
    end else if (load_seed) begin
      seed_vld <= front_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load_seed) begin
      seed <= seed_next;
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC vectoring and digit-by-digit square root, one step per stage.
  // ---------------------------------------------------------------------
  cpd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .feed_valid  (seed_vld),
    .feed_stall  (core_stall),
    .feed        (seed),
    .drain_valid (core_valid),
    .drain_stall (!load_round),
    .drain       (core_word)
  );

  // ---------------------------------------------------------------------
  // Round stage: restore the half-turn for folded points and round the
  // accumulator to Q10.7 (half up).
  // ---------------------------------------------------------------------
  logic signed [Z_WIDTH-1:0] z_offset;
  logic signed [Z_WIDTH-1:0] z_round;
  round_t                    rounded_next;

  always_comb begin
    if (!core_word.flip) begin
      z_offset = ROUND_BIAS;
    end else if (core_word.y_pos) begin
      z_offset = ROUND_BIAS + DEG180_Z;
    end else begin
      z_offset = ROUND_BIAS - DEG180_Z;
    end
    z_round               = core_word.z + z_offset;
    rounded_next.ang      = ANG_WIDTH'(z_round >>> ROUND_SHIFT);
    rounded_next.radius   = core_word.root[COORD_WIDTH-1:0];
    rounded_next.location = core_word.location;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rounded_vld <= 1'b0;
    end else if (load_round) begin
      rounded_vld <= core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_round) begin
      rounded <= rounded_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: clamp the angle to its quadrant, substitute the exact
  // angle on the axes and at the origin, and hold the word until taken.
  // ---------------------------------------------------------------------
  logic signed [ANG_WIDTH-1:0] ang_lo;
  logic signed [ANG_WIDTH-1:0] ang_hi;
  logic signed [ANG_WIDTH-1:0] ang_clamped;
  logic signed [ANG_WIDTH-1:0] ang_final;
  logic                        in_quadrant;
  polar_t                      result_next;

  always_comb begin
    in_quadrant = 1'b0;
    ang_lo      = '0;
    ang_hi      = '0;
    case (rounded.location)
      LOC_QUAD1: begin
        in_quadrant = 1'b1;
        ang_lo      = '0;
        ang_hi      = DEG90_Q7;
      end
      LOC_QUAD2: begin
        in_quadrant = 1'b1;
        ang_lo      = DEG90_Q7;
        ang_hi      = DEG180_Q7;
      end
      LOC_QUAD3: begin
        in_quadrant = 1'b1;
        ang_lo      = -DEG180_Q7;
        ang_hi      = -DEG90_Q7;
      end
      LOC_QUAD4: begin
        in_quadrant = 1'b1;
        ang_lo      = -DEG90_Q7;
        ang_hi      = '0;
      end
      default: begin
        in_quadrant = 1'b0;
      end
    endcase

    if (rounded.ang < ang_lo) begin
      ang_clamped = ang_lo;
    end else if (rounded.ang > ang_hi) begin
      ang_clamped = ang_hi;
    end else begin
      ang_clamped = rounded.ang;
    end

    case (rounded.location)
      LOC_POS_Y: ang_final = DEG90_Q7;
      LOC_NEG_Y: ang_final = -DEG90_Q7;
      LOC_NEG_X: ang_final = DEG180_Q7;
      LOC_POS_X: ang_final = '0;
      LOC_ORIGIN: ang_final = '0;
      default:   ang_final = ang_clamped;
    endcase

    result_next.radius      = rounded.radius;
    result_next.angle_deg   = ANGLE_WIDTH'(ang_final);
    result_next.location    = rounded.location;
    result_next.polar_valid = in_quadrant;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= rounded_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result <= result_next;
    end
  end

endmodule

// ===== hw/rtl/cpd_core.sv =====
`timescale 1ns / 1ps

module cpd_core
  import cpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  feed_valid,
  output logic  feed_stall,
  input  core_t feed,
  output logic  drain_valid,
  input  logic  drain_stall,
  output core_t drain
);

  core_t stage     [CORE_DEPTH];
  logic  stage_vld [CORE_DEPTH];
  logic  load      [CORE_DEPTH+1];

  assign load[CORE_DEPTH] = !drain_stall;
  assign feed_stall       = !load[0];
  assign drain_valid      = stage_vld[CORE_DEPTH-1];
  assign drain            = stage[CORE_DEPTH-1];

  for (genvar k = 0; k < CORE_DEPTH; k++) begin : g_stage
    localparam int SQ_SHIFT = (k < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - k) : 0;
    localparam logic [SQ_WIDTH-1:0]       SQ_BIT = SQ_WIDTH'(1) << SQ_SHIFT;
    localparam logic signed [Z_WIDTH-1:0] ATAN_K = Z_WIDTH'(atan_deg_q16(k));

    core_t cur;
    core_t nxt;
    logic  cur_vld;

    if (k == 0) begin : g_head
      assign cur     = feed;
      assign cur_vld = feed_valid;
    end else begin : g_body
      assign cur     = stage[k-1];
      assign cur_vld = stage_vld[k-1];
    end

    // Load when empty or when the word ahead moves on.
    assign load[k] = !stage_vld[k] || load[k+1];

    always_comb begin : p_step
      logic signed [CW_WIDTH-1:0] dx;
      logic signed [CW_WIDTH-1:0] dy;
      logic [SQ_WIDTH-1:0]        trial;
      nxt   = cur;
      dx    = cur.cy >>> k;
      dy    = cur.cx >>> k;
      trial = cur.root + SQ_BIT;
      if (k < CORDIC_STAGES) begin
        // Rotate toward the x axis.
        if (!cur.cy[CW_WIDTH-1]) begin
          nxt.cx = cur.cx + dx;
          nxt.cy = cur.cy - dy;
          nxt.z  = cur.z + ATAN_K;
        end else begin
          nxt.cx = cur.cx - dx;
          nxt.cy = cur.cy + dy;
          nxt.z  = cur.z - ATAN_K;
        end
      end
      if (k < SQRT_STEPS) begin
        // Resolve one root bit.
        if (cur.rem >= trial) begin
          nxt.rem  = cur.rem - trial;
          nxt.root = (cur.root >> 1) + SQ_BIT;
        end else begin
          nxt.root = cur.root >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_vld[k] <= 1'b0;
      end else if (load[k]) begin
        stage_vld[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (load[k]) begin
        stage[k] <= nxt;
      end
    end
  end

endmodule
